FILE: rtl/core/fifo_queued_lock_manager_assert.svh
// ----------------------------------------------------------------------------
// fifo_queued_lock_manager_assert.svh
// assertion macros used by the lock manager checker
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUED_LOCK_MANAGER_ASSERT_SVH
`define FIFO_QUEUED_LOCK_MANAGER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FQLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FQLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/flqm_pkg.sv
// ----------------------------------------------------------------------------
// flqm_pkg
// shared types and codes of the fifo queued lock manager
// ----------------------------------------------------------------------------
package flqm_pkg;

  // beat widths on both streams
  localparam int TDATA_W = 16;

  // command codes
  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result outcome codes
  typedef enum logic [2:0] {
    OC_GRANTED     = 3'd0,
    OC_QUEUED      = 3'd1,
    OC_TRANSFERRED = 3'd2,
    OC_RELEASED    = 3'd3,
    OC_REMOVED     = 3'd4,
    OC_NOT_FOUND   = 3'd5,
    OC_DUPLICATE   = 3'd6
  } outcome_t;

  // input beat layout, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0] pad;
    logic [5:0] requester;
    logic [5:0] lock_index;
    logic       command;
  } in_beat_t;

  // result fields, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0] grantee;
    logic       grant_valid;
    outcome_t   outcome;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  // field write enables of the requester table
  typedef struct packed {
    logic flags;
    logic link_nx;
    logic link_pv;
  } req_wmask_t;

endpackage

FILE: rtl/core/fifo_queued_lock_manager.sv
// ----------------------------------------------------------------------------
// fifo_queued_lock_manager
// hardware mutex bank, each lock with a fifo of waiting requesters
// ----------------------------------------------------------------------------
// Requests come in on the in_ stream (acquire or release, lock, requester),
// one result beat leaves on the out_ stream for every request beat.
// Lock state sits in a lock table; the waiter fifos are doubly linked lists
// in a per-requester table. Both tables are synchronous memories with a
// registered read, updated by read, modify and write back.
// Requests are handled one at a time; in_tready is high only while idle.
// A grant, release, duplicate or not found needs only the read state; a
// queued acquire behind other waiters adds a write state, a hand over
// adds a head read and a write state, a removal from the middle of a
// queue adds writes to both neighbours. The extra states come from the
// single write port of the requester table and the head waiter's link read.
// After reset a clearing pass over max(NUM_LOCKS, NUM_REQUESTERS) entries
// zeroes both tables; in_tready stays low until it is done.
// The result sits in an output register; a stalled receiver holds it there,
// the next request is still accepted, and its result waits until the
// register is free.
// ----------------------------------------------------------------------------
module fifo_queued_lock_manager #(
  parameter int NUM_LOCKS      = 64,
  parameter int NUM_REQUESTERS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // command[0], lock_index[6:1], requester[12:7], zero[15:13]
  input  logic [flqm_pkg::TDATA_W-1:0] in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // outcome[2:0], grant_valid[3], grantee[9:4], zero[15:10]
  output logic [flqm_pkg::TDATA_W-1:0] out_tdata
);

  localparam int LW    = $clog2(NUM_LOCKS);
  localparam int RW    = $clog2(NUM_REQUESTERS);
  localparam int CLR_N = (NUM_LOCKS > NUM_REQUESTERS) ? NUM_LOCKS : NUM_REQUESTERS;
  localparam int CW    = $clog2(CLR_N);

  typedef struct packed {
    logic          held;
    logic          nonempty;
    logic [RW-1:0] holder;
    logic [RW-1:0] head;
    logic [RW-1:0] tail;
  } lock_ent_t;

  typedef struct packed {
    logic          waiter;
    logic          owner;
    logic [LW-1:0] wlock;
  } req_flags_t;

  localparam int FW = $bits(req_flags_t);

  typedef struct packed {
    flqm_pkg::req_wmask_t mask;
    logic [RW-1:0]        addr;
    req_flags_t           flags;
    logic [RW-1:0]        link_nx;
    logic [RW-1:0]        link_pv;
  } req_wr_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_HEAD,
    S_WR,
    S_OUT
  } state_t;

  // control and payload registers
  state_t                       state_r, state_nxt;
  logic [CW-1:0]                clr_cnt_r;
  logic                         wr_idx_r;
  logic                         wr_two_r;
  req_wr_t                      slot_r [2];
  flqm_pkg::result_t            res_r;
  logic                         out_tvalid_r;
  logic [flqm_pkg::TDATA_W-1:0] out_tdata_r;
  logic                         cmd_r;
  logic [LW-1:0]                lk_r;
  logic [RW-1:0]                rq_r;
  logic                         ok_r;

  // lock table
  lock_ent_t                    lock_mem [NUM_LOCKS];
  lock_ent_t                    lock_rd_r;
  logic                         lock_we;
  logic [LW-1:0]                lock_waddr;
  lock_ent_t                    lock_wdata;

  // requester table ports
  req_wr_t                      rw;
  logic                         rq_rd_en;
  logic [RW-1:0]                rq_rd_addr;
  logic [FW-1:0]                rq_rd_flags;
  logic [RW-1:0]                rq_rd_nx;
  logic [RW-1:0]                rq_rd_pv;
  req_flags_t                   rflags;

  // decision
  lock_ent_t                    dec_lock;
  logic                         dec_lock_we;
  logic                         dec_head;
  logic [1:0]                   dec_n;
  req_wr_t                      dec_wr [3];
  flqm_pkg::result_t            dec_res;
  logic                         dec_fire;

  flqm_pkg::in_beat_t           beat;
  logic                         in_acc;
  logic                         out_free;
  logic                         clr_done;
  logic                         push;
  flqm_pkg::result_t            push_res;

  assign beat       = flqm_pkg::in_beat_t'(in_tdata);
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign clr_done   = (clr_cnt_r == CW'(CLR_N - 1));
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign rflags     = req_flags_t'(rq_rd_flags);
  assign dec_fire   = (state_r == S_HEAD) || ((state_r == S_READ) && !dec_head);

  // lock table: write port and registered read on accept
  always_ff @(posedge clk) begin
    if (lock_we) begin
      lock_mem[lock_waddr] <= lock_wdata;
    end
    if (in_acc) begin
      lock_rd_r <= lock_mem[LW'(beat.lock_index)];
    end
  end

  // lock table write source: clearing pass or the decision
  always_comb begin
    if (state_r == S_CLEAR) begin
      lock_we    = (32'(clr_cnt_r) < 32'(NUM_LOCKS));
      lock_waddr = LW'(clr_cnt_r);
      lock_wdata = '0;
    end else begin
      lock_we    = dec_fire && dec_lock_we;
      lock_waddr = lk_r;
      lock_wdata = dec_lock;
    end
  end

  // requester table write source: clearing pass, first slot, queued slots
  always_comb begin
    rw = '0;
    if (state_r == S_CLEAR) begin
      if (32'(clr_cnt_r) < 32'(NUM_REQUESTERS)) begin
        rw.mask = '1;
      end
      rw.addr = RW'(clr_cnt_r);
    end else if (dec_fire) begin
      rw = dec_wr[0];
    end else if (state_r == S_WR) begin
      rw = slot_r[wr_idx_r];
    end
  end

  // requester table read: own entry on accept, head waiter on hand over
  assign rq_rd_en   = in_acc || ((state_r == S_READ) && dec_head);
  assign rq_rd_addr = in_acc ? RW'(beat.requester) : lock_rd_r.head;

  flqm_req_ram #(
    .DEPTH (NUM_REQUESTERS),
    .FW    (FW)
  ) u_req_ram (
    .clk        (clk),
    .wr_mask    (rw.mask),
    .wr_addr    (rw.addr),
    .wr_flags   (rw.flags),
    .wr_link_nx (rw.link_nx),
    .wr_link_pv (rw.link_pv),
    .rd_en      (rq_rd_en),
    .rd_addr    (rq_rd_addr),
    .rd_flags   (rq_rd_flags),
    .rd_link_nx (rq_rd_nx),
    .rd_link_pv (rq_rd_pv)
  );

  // decision on the read entries
  always_comb begin
    dec_lock            = lock_rd_r;
    dec_lock_we         = 1'b0;
    dec_head            = 1'b0;
    dec_n               = 2'd0;
    dec_res.outcome     = flqm_pkg::OC_NOT_FOUND;
    dec_res.grant_valid = 1'b0;
    dec_res.grantee     = '0;
    for (int i = 0; i < 3; i++) begin
      dec_wr[i] = '0;
    end

    if (state_r == S_HEAD) begin
      // hand over to the head waiter, read entry is the head's
      dec_lock_we     = 1'b1;
      dec_lock.holder = lock_rd_r.head;
      if (lock_rd_r.head == lock_rd_r.tail) begin
        dec_lock.nonempty = 1'b0;
      end else begin
        dec_lock.head = rq_rd_nx;
      end
      dec_wr[0].mask.flags  = 1'b1;
      dec_wr[0].addr        = rq_r;
      dec_wr[1].mask.flags  = 1'b1;
      dec_wr[1].addr        = lock_rd_r.head;
      dec_wr[1].flags.owner = 1'b1;
      dec_n                 = 2'd1;
      dec_res.outcome       = flqm_pkg::OC_TRANSFERRED;
      dec_res.grant_valid   = 1'b1;
      dec_res.grantee       = 6'(lock_rd_r.head);
    end else if (!ok_r) begin
      dec_res.outcome = flqm_pkg::OC_NOT_FOUND;
    end else if (cmd_r == flqm_pkg::CMD_ACQUIRE) begin
      if (rflags.owner || rflags.waiter) begin
        dec_res.outcome = flqm_pkg::OC_DUPLICATE;
      end else if (!lock_rd_r.held) begin
        // free lock: grant at once
        dec_lock_we           = 1'b1;
        dec_lock.held         = 1'b1;
        dec_lock.holder       = rq_r;
        dec_wr[0].mask.flags  = 1'b1;
        dec_wr[0].addr        = rq_r;
        dec_wr[0].flags.owner = 1'b1;
        dec_res.outcome       = flqm_pkg::OC_GRANTED;
        dec_res.grant_valid   = 1'b1;
        dec_res.grantee       = 6'(rq_r);
      end else begin
        // held lock: append at the tail
        dec_lock_we   = 1'b1;
        dec_lock.tail = rq_r;
        if (!lock_rd_r.nonempty) begin
          dec_lock.head     = rq_r;
          dec_lock.nonempty = 1'b1;
        end
        dec_wr[0].mask.flags   = 1'b1;
        dec_wr[0].mask.link_pv = 1'b1;
        dec_wr[0].addr         = rq_r;
        dec_wr[0].flags.waiter = 1'b1;
        dec_wr[0].flags.wlock  = lk_r;
        dec_wr[0].link_pv      = lock_rd_r.tail;
        if (lock_rd_r.nonempty) begin
          dec_wr[1].mask.link_nx = 1'b1;
          dec_wr[1].addr         = lock_rd_r.tail;
          dec_wr[1].link_nx      = rq_r;
          dec_n                  = 2'd1;
        end
        dec_res.outcome = flqm_pkg::OC_QUEUED;
      end
    end else begin
      if (lock_rd_r.held && (lock_rd_r.holder == rq_r)) begin
        if (lock_rd_r.nonempty) begin
          dec_head = 1'b1;
        end else begin
          dec_lock_we          = 1'b1;
          dec_lock.held        = 1'b0;
          dec_wr[0].mask.flags = 1'b1;
          dec_wr[0].addr       = rq_r;
          dec_res.outcome      = flqm_pkg::OC_RELEASED;
        end
      end else if (rflags.waiter && (rflags.wlock == lk_r)) begin
        // unlink a waiter from anywhere in the queue
        dec_lock_we          = 1'b1;
        dec_wr[0].mask.flags = 1'b1;
        dec_wr[0].addr       = rq_r;
        if ((lock_rd_r.head == rq_r) && (lock_rd_r.tail == rq_r)) begin
          dec_lock.nonempty = 1'b0;
        end else if (lock_rd_r.head == rq_r) begin
          dec_lock.head = rq_rd_nx;
        end else if (lock_rd_r.tail == rq_r) begin
          dec_lock.tail = rq_rd_pv;
        end else begin
          dec_wr[1].mask.link_nx = 1'b1;
          dec_wr[1].addr         = rq_rd_pv;
          dec_wr[1].link_nx      = rq_rd_nx;
          dec_wr[2].mask.link_pv = 1'b1;
          dec_wr[2].addr         = rq_rd_nx;
          dec_wr[2].link_pv      = rq_rd_pv;
          dec_n                  = 2'd2;
        end
        dec_res.outcome = flqm_pkg::OC_REMOVED;
      end
    end
  end

  // sequencer next state and result push
  always_comb begin
    state_nxt = state_r;
    push      = 1'b0;
    push_res  = res_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_READ;
        end
      end
      S_READ, S_HEAD: begin
        push_res = dec_res;
        if (dec_head) begin
          state_nxt = S_HEAD;
        end else if (dec_n != 2'd0) begin
          state_nxt = S_WR;
        end else if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_WR: begin
        if (!wr_idx_r && wr_two_r) begin
          state_nxt = S_WR;
        end else if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      wr_idx_r     <= 1'b0;
      wr_two_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (dec_fire) begin
        wr_idx_r <= 1'b0;
        wr_two_r <= (dec_n == 2'd2);
      end else if (state_r == S_WR) begin
        wr_idx_r <= 1'b1;
      end
      if (push) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    // payload
    if (push) begin
      out_tdata_r <= {(flqm_pkg::TDATA_W - flqm_pkg::RESULT_W)'(0), push_res};
    end
    if (dec_fire) begin
      slot_r[0] <= dec_wr[1];
      slot_r[1] <= dec_wr[2];
      res_r     <= dec_res;
    end
    if (in_acc) begin
      cmd_r <= beat.command;
      lk_r  <= LW'(beat.lock_index);
      rq_r  <= RW'(beat.requester);
      ok_r  <= (32'(beat.lock_index) < 32'(NUM_LOCKS)) &&
               (32'(beat.requester) < 32'(NUM_REQUESTERS));
    end
  end

endmodule

FILE: rtl/core/flqm_req_ram.sv
// ----------------------------------------------------------------------------
// flqm_req_ram
// per-requester table: flags, next link and previous link, one write port
// with field enables, one registered read port
// ----------------------------------------------------------------------------
module flqm_req_ram #(
  parameter int DEPTH = 64,
  parameter int FW    = 8
) (
  input  logic                        clk,
  input  flqm_pkg::req_wmask_t        wr_mask,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [FW-1:0]               wr_flags,
  input  logic [$clog2(DEPTH)-1:0]    wr_link_nx,
  input  logic [$clog2(DEPTH)-1:0]    wr_link_pv,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic [FW-1:0]               rd_flags,
  output logic [$clog2(DEPTH)-1:0]    rd_link_nx,
  output logic [$clog2(DEPTH)-1:0]    rd_link_pv
);

  localparam int AW = $clog2(DEPTH);

  logic [FW-1:0] flags_mem [DEPTH];
  logic [AW-1:0] nx_mem    [DEPTH];
  logic [AW-1:0] pv_mem    [DEPTH];

  // field-masked write, registered read
  always_ff @(posedge clk) begin
    if (wr_mask.flags) begin
      flags_mem[wr_addr] <= wr_flags;
    end
    if (wr_mask.link_nx) begin
      nx_mem[wr_addr] <= wr_link_nx;
    end
    if (wr_mask.link_pv) begin
      pv_mem[wr_addr] <= wr_link_pv;
    end
    if (rd_en) begin
      rd_flags   <= flags_mem[rd_addr];
      rd_link_nx <= nx_mem[rd_addr];
      rd_link_pv <= pv_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/flqm_checker.sv
// ----------------------------------------------------------------------------
// flqm_checker
// port-level checks of the fifo queued lock manager, bound to the top level
// ----------------------------------------------------------------------------
`include "fifo_queued_lock_manager_assert.svh"

module flqm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [flqm_pkg::TDATA_W-1:0] out_tdata
);

  flqm_pkg::result_t res;

  assign res = flqm_pkg::result_t'(out_tdata[flqm_pkg::RESULT_W-1:0]);

  // stalled result beat holds
  `FQLM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // one request in flight: no accept right after an accept
  `FQLM_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request accepted while another is in flight")

  // grant flag only with a grant or a hand over
  `FQLM_ASSERT_IMP(a_grant_code, out_tvalid, res.grant_valid == ((res.outcome == flqm_pkg::OC_GRANTED) || (res.outcome == flqm_pkg::OC_TRANSFERRED)), "grant flag disagrees with outcome")

  // no grantee without a grant
  `FQLM_ASSERT_IMP(a_grantee_zero, out_tvalid && !res.grant_valid, res.grantee == '0, "grantee set without a grant")

endmodule

bind fifo_queued_lock_manager flqm_checker u_flqm_checker (.*);

FILE: dv/fifo_queued_lock_manager_tb.sv
// ----------------------------------------------------------------------------
// fifo_queued_lock_manager_tb
// self-checking bench for the fifo queued lock manager
// ----------------------------------------------------------------------------
// Request beats go in as acquire or release commands. A directed run comes
// first: grants, duplicates, strangers and removals at the head, the middle
// and the tail of a queue, plus hand-overs. A long random run follows. It
// mostly sends sensible traffic on a few hot locks: holders release and
// waiters leave, with some random noise mixed in. Both streams idle at
// random, except for one long stretch with no gaps. A lock and waiter model
// in the scoreboard predicts every result beat, and each beat is checked
// field by field.
// ----------------------------------------------------------------------------
module fifo_queued_lock_manager_tb;

  localparam int NLOCKS      = 64;
  localparam int NREQ        = 64;
  localparam int RAND_ITEMS  = 1400;
  localparam int STALL_LIMIT = 5000;

  // lock and waiter model, plus the queue of predicted results
  class lock_outcome_checker;
    bit                lock_held   [NLOCKS];
    bit [5:0]          lock_holder [NLOCKS];
    bit [5:0]          fifo_head   [NLOCKS];
    bit [5:0]          fifo_tail   [NLOCKS];
    bit                fifo_busy   [NLOCKS];
    bit                is_waiting  [NREQ];
    bit                is_owner    [NREQ];
    bit [5:0]          link_next   [NREQ];
    bit [5:0]          link_prev   [NREQ];
    bit [5:0]          waits_on    [NREQ];
    bit [5:0]          owned_lock  [NREQ];
    flqm_pkg::result_t pending_outcomes[$];
    int                mismatches;

    function int outstanding();
      return pending_outcomes.size();
    endfunction

    // take a waiter out of its lock's fifo, wherever it sits
    function void drop_waiter(bit [5:0] lk, bit [5:0] rq);
      bit [5:0] nx;
      bit [5:0] pv;
      nx = link_next[rq];
      pv = link_prev[rq];
      if (fifo_head[lk] == rq && fifo_tail[lk] == rq) begin
        fifo_busy[lk] = 1'b0;
      end else if (fifo_head[lk] == rq) begin
        fifo_head[lk] = nx;
      end else if (fifo_tail[lk] == rq) begin
        fifo_tail[lk] = pv;
      end else begin
        link_next[pv] = nx;
        link_prev[nx] = pv;
      end
      is_waiting[rq] = 1'b0;
    endfunction

    // outcome of one request; with 64 locks and requesters every index is valid
    function flqm_pkg::result_t predict_outcome(logic cmd, bit [5:0] lk, bit [5:0] rq);
      flqm_pkg::result_t res;
      bit [5:0]          heir;
      res = '0;
      res.outcome = flqm_pkg::OC_NOT_FOUND;
      if (cmd == flqm_pkg::CMD_ACQUIRE) begin
        if (is_owner[rq] || is_waiting[rq]) begin
          res.outcome = flqm_pkg::OC_DUPLICATE;
        end else if (!lock_held[lk]) begin
          lock_held[lk]   = 1'b1;
          lock_holder[lk] = rq;
          is_owner[rq]    = 1'b1;
          owned_lock[rq]  = lk;
          res.outcome     = flqm_pkg::OC_GRANTED;
          res.grant_valid = 1'b1;
          res.grantee     = rq;
        end else begin
          if (fifo_busy[lk]) begin
            link_next[fifo_tail[lk]] = rq;
            link_prev[rq] = fifo_tail[lk];
          end else begin
            fifo_head[lk] = rq;
            fifo_busy[lk] = 1'b1;
          end
          fifo_tail[lk]  = rq;
          is_waiting[rq] = 1'b1;
          waits_on[rq]   = lk;
          res.outcome    = flqm_pkg::OC_QUEUED;
        end
      end else if (lock_held[lk] && lock_holder[lk] == rq) begin
        is_owner[rq] = 1'b0;
        if (fifo_busy[lk]) begin
          // hand the lock to the head waiter
          heir = fifo_head[lk];
          drop_waiter(lk, heir);
          lock_holder[lk]  = heir;
          is_owner[heir]   = 1'b1;
          owned_lock[heir] = lk;
          res.outcome      = flqm_pkg::OC_TRANSFERRED;
          res.grant_valid  = 1'b1;
          res.grantee      = heir;
        end else begin
          lock_held[lk] = 1'b0;
          res.outcome   = flqm_pkg::OC_RELEASED;
        end
      end else if (is_waiting[rq] && waits_on[rq] == lk) begin
        drop_waiter(lk, rq);
        res.outcome = flqm_pkg::OC_REMOVED;
      end
      return res;
    endfunction

    function void note_request(flqm_pkg::in_beat_t b);
      pending_outcomes.push_back(predict_outcome(b.command, b.lock_index, b.requester));
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      mismatches++;
    endtask

    task check_result(flqm_pkg::result_t got);
      flqm_pkg::result_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result beat with no request", 8'(got.outcome), 8'd0);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.outcome !== want.outcome)
        report_mismatch("outcome", 8'(got.outcome), 8'(want.outcome));
      if (got.grant_valid !== want.grant_valid)
        report_mismatch("grant_valid", 8'(got.grant_valid), 8'(want.grant_valid));
      if (got.grantee !== want.grantee)
        report_mismatch("grantee", 8'(got.grantee), 8'(want.grantee));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [flqm_pkg::TDATA_W-1:0] in_tdata   = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [flqm_pkg::TDATA_W-1:0] out_tdata;

  lock_outcome_checker sb = new();
  bit                  no_gaps = 1'b0;
  int                  quiet_cycles = 0;

  fifo_queued_lock_manager #(
    .NUM_LOCKS      (NLOCKS),
    .NUM_REQUESTERS (NREQ)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver drops out_tready at random about 30 percent of the time, except in the no-gaps stretch
  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 30);
  end

  // beat monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_request(flqm_pkg::in_beat_t'(in_tdata));
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(flqm_pkg::result_t'(out_tdata[flqm_pkg::RESULT_W-1:0]));
    quiet_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ?
                    0 : quiet_cycles + 1;
  end

  // watchdog on cycles with no beat moving
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // present one request beat, with a random gap in front, until accepted
  task automatic send_beat(input logic cmd, input logic [5:0] lk, input logic [5:0] rq);
    flqm_pkg::in_beat_t b;
    b = '0;
    b.command    = cmd;
    b.lock_index = lk;
    b.requester  = rq;
    if (!no_gaps && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic run_directed();
    // extremes and duplicates
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd0, 6'd0);
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd63, 6'd63);
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd0, 6'd63);
    // build a queue of four on lock 0
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd0, 6'd1);
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd0, 6'd2);
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd0, 6'd3);
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd0, 6'd4);
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd5, 6'd2);
    // removal from the middle and from the tail
    send_beat(flqm_pkg::CMD_RELEASE, 6'd0, 6'd2);
    send_beat(flqm_pkg::CMD_RELEASE, 6'd0, 6'd4);
    // waiter on another lock, and a plain stranger
    send_beat(flqm_pkg::CMD_RELEASE, 6'd5, 6'd3);
    send_beat(flqm_pkg::CMD_RELEASE, 6'd42, 6'd21);
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd42, 6'd21);
    send_beat(flqm_pkg::CMD_RELEASE, 6'd42, 6'd21);
    // hand over with more than one waiter, then head removals
    send_beat(flqm_pkg::CMD_RELEASE, 6'd0, 6'd0);
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd0, 6'd5);
    send_beat(flqm_pkg::CMD_RELEASE, 6'd0, 6'd3);
    send_beat(flqm_pkg::CMD_RELEASE, 6'd0, 6'd5);
    // hand over to a lone waiter, then plain releases and a repeated release
    send_beat(flqm_pkg::CMD_ACQUIRE, 6'd0, 6'd7);
    send_beat(flqm_pkg::CMD_RELEASE, 6'd0, 6'd1);
    send_beat(flqm_pkg::CMD_RELEASE, 6'd0, 6'd7);
    send_beat(flqm_pkg::CMD_RELEASE, 6'd63, 6'd63);
    send_beat(flqm_pkg::CMD_RELEASE, 6'd63, 6'd63);
  endtask

  task automatic run_random();
    int unsigned i;
    int unsigned roll;
    bit          narrow;
    bit [5:0]    lk;
    bit [5:0]    rq;
    logic        cmd;
    for (i = 0; i < RAND_ITEMS; i++) begin
      no_gaps = (i >= 500 && i < 800);
      // now and then hold off until every result is back
      if (i % 300 == 150) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
      end
      // most traffic on a few hot locks and requesters
      narrow = ($urandom_range(99) < 80);
      rq   = narrow ? 6'($urandom_range(11)) : 6'($urandom_range(63));
      lk   = narrow ? 6'($urandom_range(3))  : 6'($urandom_range(63));
      cmd  = flqm_pkg::CMD_ACQUIRE;
      roll = $urandom_range(99);
      if (roll < 12) begin
        cmd = $urandom_range(1) ? flqm_pkg::CMD_RELEASE : flqm_pkg::CMD_ACQUIRE;
      end else if (sb.is_owner[rq]) begin
        cmd = flqm_pkg::CMD_RELEASE;
        lk  = sb.owned_lock[rq];
      end else if (sb.is_waiting[rq]) begin
        // either the waiter leaves or its holder lets go
        cmd = flqm_pkg::CMD_RELEASE;
        lk  = sb.waits_on[rq];
        if (roll < 70) rq = sb.lock_holder[lk];
      end
      send_beat(cmd, lk, rq);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/flqm_pkg.sv
rtl/core/flqm_req_ram.sv
rtl/core/fifo_queued_lock_manager.sv
rtl/core/flqm_checker.sv
dv/fifo_queued_lock_manager_tb.sv
